[rtl/los_pkg.sv]
// Package with the shared types and constants of the obstacle steering block.
`timescale 1ns / 1ps

package los_pkg;

   // Command codes on the request port.
   localparam logic [1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [1:0] CMD_COMPASS = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_TARGET    = 3'd1;
   localparam logic [2:0] REG_OFFSET    = 3'd2;
   localparam logic [2:0] REG_MAX_FLIPS = 3'd3;
   localparam logic [2:0] REG_WINDOW    = 3'd4;

   localparam logic [15:0] RANGE_MAX = 16'hFFFF;
   localparam logic [8:0]  DEG_FULL  = 9'd360;

   localparam logic [4:0] SPEED_STOP   = 5'd0;
   localparam logic [4:0] SPEED_GENTLE = 5'd20;
   localparam logic [4:0] SPEED_FULL   = 5'd30;

   localparam logic signed [6:0] TURN_HARD_LEFT  = 7'sd40;
   localparam logic signed [6:0] TURN_LEFT       = 7'sd20;
   localparam logic signed [6:0] TURN_NONE       = 7'sd0;
   localparam logic signed [6:0] TURN_RIGHT      = -7'sd20;
   localparam logic signed [6:0] TURN_HARD_RIGHT = -7'sd40;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_COMPASS,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  index;
      logic [15:0] range_mm;
      logic [8:0]  heading_deg;
   } entry_type;

   // Head of the queue as seen by the execution side.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

endpackage

[rtl/los_front.sv]
// Front end: accepts requests, drops those without effect and queues the rest.
`timescale 1ns / 1ps

module los_front import los_pkg::*; #(
   parameter int WINDOW = 90
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  logic [1:0]     req_command,
   input  logic [6:0]     req_sample_index,
   input  logic [15:0]    req_range_mm,
   input  logic [8:0]     req_heading_deg,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type            q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 accept;
   logic                 keep;
   logic                 push;
   logic                 do_pop;
   entry_type            new_entry;

   assign busy   = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign accept = start && !busy;

   // Classify the request: out-of-window samples and the unused code vanish here.
   always_comb begin
      keep      = 1'b0;
      new_entry = '{op: OP_SAMPLE, index: req_sample_index, range_mm: req_range_mm,
                    heading_deg: req_heading_deg};
      case (req_command)
         CMD_SAMPLE: begin
            keep         = ({2'b00, req_sample_index} < 9'(WINDOW));
            new_entry.op = OP_SAMPLE;
         end
         CMD_COMPASS: begin
            keep         = 1'b1;
            new_entry.op = OP_COMPASS;
         end
         CMD_TICK: begin
            keep         = 1'b1;
            new_entry.op = OP_TICK;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push   = accept && keep;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head = '{valid: (count_ff != '0), entry: q_ff[rd_ptr_ff]};

endmodule

[rtl/los_back.sv]
// Back end: range store, heading, window scan and steering decision.
`timescale 1ns / 1ps

module los_back import los_pkg::*; #(
   parameter int WINDOW = 90
) (
   input  logic               clock,
   input  logic               reset,
   input  queue_head_type     head,
   output logic               pop,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [4:0]         rsp_linear_speed,
   output logic signed [6:0]  rsp_turn_rate,
   output logic               rsp_obstacle_seen,
   output logic [6:0]         rsp_nearest_index
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW - 1);
   localparam logic [IDX_W-1:0] LEFT_LAST = IDX_W'(WINDOW / 2);

   // Configuration registers.
   logic [15:0] thr_ff;
   logic [8:0]  tgt_ff;
   logic [8:0]  ofs_ff;
   logic [3:0]  max_flips_ff;
   logic [7:0]  tw_ff;

   state_type state_ff, state_in;

   logic [15:0]      mem [WINDOW];
   logic [WINDOW-1:0] written_ff;

   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic [15:0]      rd_data_ff;
   logic             rd_written_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_live_ff;

   logic [15:0]      best_v_ff;
   logic [IDX_W-1:0] best_i_ff;

   logic       heading_valid_ff;
   logic [8:0] heading_ff, heading_in;
   logic [3:0] flip_ff, flip_in;
   logic       last_valid_ff, last_valid_in;
   logic       last_left_ff, last_left_in;

   logic             rsp_valid_ff;
   logic [4:0]       lin_ff, lin_in;
   logic signed [6:0] turn_ff, turn_in;
   logic             seen_ff;
   logic [6:0]       near_ff;

   logic do_sample;
   logic do_compass;
   logic scan_en;
   logic decide_en;
   logic [IDX_W-1:0] wr_idx;
   logic [15:0]      cur_v;
   logic             take;
   logic             seen;
   logic             left;

   logic [8:0]  raw_b, ofs_b;
   logic signed [9:0] hdiff;

   logic signed [10:0] h_s, d, dp, dm, tw_s, ntw_s;
   logic cond_left, cond_right;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid && head.entry.op == OP_TICK) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      pop        = 1'b0;
      do_sample  = 1'b0;
      do_compass = 1'b0;
      scan_en    = 1'b0;
      decide_en  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pop        = head.valid;
            do_sample  = head.valid && head.entry.op == OP_SAMPLE;
            do_compass = head.valid && head.entry.op == OP_COMPASS;
         end
         ST_SCAN: begin
            scan_en = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DECIDE: begin
            decide_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= 16'd400;
         tgt_ff       <= 9'd285;
         ofs_ff       <= 9'd25;
         max_flips_ff <= 4'd2;
         tw_ff        <= 8'd150;
      end else if (csr_we) begin
         case (csr_index)
            REG_THRESHOLD: thr_ff       <= csr_wdata;
            REG_TARGET:    tgt_ff       <= csr_wdata[8:0];
            REG_OFFSET:    ofs_ff       <= csr_wdata[8:0];
            REG_MAX_FLIPS: max_flips_ff <= csr_wdata[3:0];
            REG_WINDOW:    tw_ff        <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Range store; an entry never written reads as maximum range.
   assign wr_idx = IDX_W'(head.entry.index);

   always_ff @(posedge clock) begin
      if (do_sample) begin
         mem[wr_idx] <= head.entry.range_mm;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (do_sample) begin
         written_ff[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      rd_addr_in = rd_addr_ff;
      if (scan_en) begin
         rd_addr_in = rd_addr_ff + 1'b1;
      end else if (state_ff == ST_IDLE) begin
         rd_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         rd_addr_ff <= rd_addr_in;
         rd_live_ff <= scan_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_written_ff <= written_ff[rd_addr_ff];
      rd_idx_ff     <= rd_addr_ff;
   end

   // Running first minimum: only a strictly smaller value replaces it.
   assign cur_v = rd_written_ff ? rd_data_ff : RANGE_MAX;
   assign take  = rd_live_ff && (rd_idx_ff == '0 || cur_v < best_v_ff);

   always_ff @(posedge clock) begin
      if (take) begin
         best_v_ff <= cur_v;
         best_i_ff <= rd_idx_ff;
      end
   end

   // Compass reading, corrected by the mounting offset and wrapped.
   always_comb begin
      raw_b      = (head.entry.heading_deg >= DEG_FULL) ? head.entry.heading_deg - DEG_FULL
                                                        : head.entry.heading_deg;
      ofs_b      = (ofs_ff >= DEG_FULL) ? ofs_ff - DEG_FULL : ofs_ff;
      hdiff      = $signed({1'b0, raw_b}) - $signed({1'b0, ofs_b});
      heading_in = (hdiff < 0) ? 9'(hdiff + 10'sd360) : hdiff[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_valid_ff <= 1'b0;
         heading_ff       <= '0;
      end else if (do_compass) begin
         heading_valid_ff <= 1'b1;
         heading_ff       <= heading_in;
      end
   end

   // Steering decision.
   always_comb begin
      seen  = (best_v_ff <= thr_ff);
      left  = (best_i_ff <= LEFT_LAST);
      h_s   = heading_valid_ff ? $signed({2'b00, heading_ff}) : -11'sd1;
      d     = h_s - $signed({2'b00, tgt_ff});
      dp    = d + 11'sd360;
      dm    = d - 11'sd360;
      tw_s  = $signed({3'b000, tw_ff});
      ntw_s = -tw_s;
      cond_left  = (d <= tw_s && d > 11'sd1) || (dp <= tw_s && dp > 11'sd1);
      cond_right = (d < -11'sd1 && d >= ntw_s) || (dm <= -11'sd1 && dm >= ntw_s);

      flip_in       = flip_ff;
      last_valid_in = last_valid_ff;
      last_left_in  = last_left_ff;
      lin_in        = SPEED_STOP;
      turn_in       = TURN_HARD_RIGHT;
      if (seen) begin
         lin_in = SPEED_STOP;
         if (flip_ff >= max_flips_ff) begin
            turn_in = TURN_HARD_RIGHT;
         end else begin
            turn_in = left ? TURN_HARD_LEFT : TURN_HARD_RIGHT;
            if (last_valid_ff && (last_left_ff != left)) begin
               flip_in = flip_ff + 1'b1;
            end
         end
         last_valid_in = 1'b1;
         last_left_in  = left;
      end else begin
         flip_in       = '0;
         last_valid_in = 1'b0;
         if (cond_left) begin
            lin_in  = SPEED_GENTLE;
            turn_in = TURN_LEFT;
         end else if (cond_right) begin
            lin_in  = SPEED_GENTLE;
            turn_in = TURN_RIGHT;
         end else if (d == 11'sd0) begin
            lin_in  = SPEED_FULL;
            turn_in = TURN_NONE;
         end else begin
            lin_in  = SPEED_STOP;
            turn_in = TURN_HARD_RIGHT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff       <= '0;
         last_valid_ff <= 1'b0;
         last_left_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= decide_en;
         if (decide_en) begin
            flip_ff       <= flip_in;
            last_valid_ff <= last_valid_in;
            last_left_ff  <= last_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (decide_en) begin
         lin_ff  <= lin_in;
         turn_ff <= turn_in;
         seen_ff <= seen;
         near_ff <= 7'(best_i_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_linear_speed  = lin_ff;
   assign rsp_turn_rate     = turn_ff;
   assign rsp_obstacle_seen = seen_ff;
   assign rsp_nearest_index = near_ff;

endmodule

[rtl/lidar_obstacle_steering.sv]
// Top level of the obstacle steering controller: request queue and execution side.
//
//  Channel   Ports                                  Handshake
//  request   req_command/sample_index/range_mm/     taken when start high and busy low
//            heading_deg
//  response  rsp_linear_speed/turn_rate/            rsp_valid high for one cycle
//            obstacle_seen/nearest_index
//  config    csr_we, csr_index, csr_wdata           written when csr_we is high
//
// A request enters a four-entry queue; busy is high while the queue is full.
// Range samples and compass readings take effect in the cycle they are popped.
// A decision tick scans one store entry per cycle through the registered read
// port, then passes the drain and decide states before its response is shown.
// Reset clears control state and marks every store entry unwritten, so no
// clearing pass runs. The response cannot be held off.
`timescale 1ns / 1ps

module lidar_obstacle_steering import los_pkg::*; #(
   parameter int WINDOW = 90
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [6:0]        req_sample_index,
   input  logic [15:0]       req_range_mm,
   input  logic [8:0]        req_heading_deg,
   output logic              rsp_valid,
   output logic [4:0]        rsp_linear_speed,
   output logic signed [6:0] rsp_turn_rate,
   output logic              rsp_obstacle_seen,
   output logic [6:0]        rsp_nearest_index,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   queue_head_type head;
   logic           pop;

   los_front #(
      .WINDOW(WINDOW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_sample_index (req_sample_index),
      .req_range_mm     (req_range_mm),
      .req_heading_deg  (req_heading_deg),
      .head             (head),
      .pop              (pop)
   );

   los_back #(
      .WINDOW(WINDOW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_turn_rate     (rsp_turn_rate),
      .rsp_obstacle_seen (rsp_obstacle_seen),
      .rsp_nearest_index (rsp_nearest_index)
   );

endmodule
